// ===== design/pwg_raster_line_run_encoder_macros.svh =====
// assertion macros shared by the run encoder rtl
`ifndef PWG_RASTER_LINE_RUN_ENCODER_MACROS_SVH
`define PWG_RASTER_LINE_RUN_ENCODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define PWGRLE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PWGRLE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/pwgrle_pkg.sv =====
// shared types, constants and helpers of the raster line run encoder
package pwgrle_pkg;

    localparam int unsigned MAX_RUN_DEF = 128;
    localparam int unsigned PPR_DEF     = 4;

    localparam int unsigned PIX_W   = 24;
    localparam int unsigned GRAY_W  = 8;
    localparam int unsigned LEN_W   = 8;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned PCNT_W  = 3;
    localparam int unsigned RES_PIX = 4;

    // m_tdata layout, lowest bit first
    localparam int unsigned TD_CNT_LSB  = 0;
    localparam int unsigned TD_PCNT_LSB = TD_CNT_LSB + CNT_W;
    localparam int unsigned TD_PIX_LSB  = TD_PCNT_LSB + PCNT_W;
    localparam int unsigned TD_LOS_BIT  = TD_PIX_LSB + RES_PIX * PIX_W;
    localparam int unsigned TD_USED_W   = TD_LOS_BIT + 1;
    localparam int unsigned TDATA_W     = ((TD_USED_W + 7) / 8) * 8;
    localparam int unsigned TD_PAD_W    = TDATA_W - TD_USED_W;

    typedef enum logic [1:0] {
        MODE_EMPTY   = 2'd0,
        MODE_REPEAT  = 2'd1,
        MODE_LITERAL = 2'd2
    } run_mode_t;

    typedef enum logic [1:0] {
        DR_IDLE    = 2'd0,
        DR_COLLECT = 2'd1,
        DR_HOLD    = 2'd2
    } drain_state_t;

    // one run to emit; a repeat run carries its pixel and a length of one
    typedef struct packed {
        logic             lit;
        logic [CNT_W-1:0] count;
        logic [PIX_W-1:0] pixel;
        logic [LEN_W-1:0] len;
    } run_t;

    // runs closed by one accepted pixel
    typedef struct packed {
        run_t first;
        run_t second;
        logic second_vld;
        logic eol;
    } job_t;

    typedef struct packed {
        logic                          has_count;
        logic [CNT_W-1:0]              count_byte;
        logic [PCNT_W-1:0]             pixel_count;
        logic [RES_PIX-1:0][PIX_W-1:0] pix;
        logic                          line_done;
        logic                          last_of_step;
    } result_t;

    // literal count byte: 257 - n, or 0 for a single pixel
    function automatic logic [CNT_W-1:0] lit_count(input logic [LEN_W-1:0] n);
        logic [CNT_W:0] diff;
        diff = (CNT_W + 1)'(257) - {1'b0, n};
        return (n == LEN_W'(1)) ? '0 : diff[CNT_W-1:0];
    endfunction

endpackage

// ===== design/pwgrle_store.sv =====
// two-bank literal pixel store, even indexes in bank 0, odd in bank 1
module pwgrle_store #(
    parameter int unsigned ADDR_W = 6
) (
    input  logic                         aclk,
    input  logic                         wr0_en,
    input  logic [ADDR_W-1:0]            wr0_addr,
    input  logic [pwgrle_pkg::PIX_W-1:0] wr0_data,
    input  logic                         wr1_en,
    input  logic [ADDR_W-1:0]            wr1_addr,
    input  logic [pwgrle_pkg::PIX_W-1:0] wr1_data,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [pwgrle_pkg::PIX_W-1:0] rd0_data,
    output logic [pwgrle_pkg::PIX_W-1:0] rd1_data
);

    localparam int unsigned BANK_DEPTH = 1 << ADDR_W;

    logic [pwgrle_pkg::PIX_W-1:0] bank0_mem [BANK_DEPTH];
    logic [pwgrle_pkg::PIX_W-1:0] bank1_mem [BANK_DEPTH];
    logic [pwgrle_pkg::PIX_W-1:0] rd0_reg;
    logic [pwgrle_pkg::PIX_W-1:0] rd1_reg;

    always_ff @(posedge aclk) begin
        if (wr0_en) begin
            bank0_mem[wr0_addr] <= wr0_data;
        end
        if (wr1_en) begin
            bank1_mem[wr1_addr] <= wr1_data;
        end
    end

    // a read issued on the cycle of a write to the same entry sees the new pixel
    always_ff @(posedge aclk) begin
        rd0_reg <= (wr0_en && (wr0_addr == rd_addr)) ? wr0_data : bank0_mem[rd_addr];
        rd1_reg <= (wr1_en && (wr1_addr == rd_addr)) ? wr1_data : bank1_mem[rd_addr];
    end

    assign rd0_data = rd0_reg;
    assign rd1_data = rd1_reg;

endmodule

// ===== design/pwgrle_drain.sv =====
// result sequencer: walks closed runs, packs beats and owns the output register
module pwgrle_drain #(
    parameter int unsigned PIXELS_PER_RESULT = pwgrle_pkg::PPR_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           job_start,
    input  pwgrle_pkg::job_t               job,
    output logic                           busy,
    output logic [pwgrle_pkg::LEN_W-1:0]   rd_index,
    input  logic [pwgrle_pkg::PIX_W-1:0]   rd0_data,
    input  logic [pwgrle_pkg::PIX_W-1:0]   rd1_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pwgrle_pkg::TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);

    pwgrle_pkg::drain_state_t state_reg, state_next;
    pwgrle_pkg::run_t         cur_reg, cur_next;
    pwgrle_pkg::run_t         nxt_reg, nxt_next;
    logic                     nxt_vld_reg, nxt_vld_next;
    logic                     eol_reg, eol_next;
    logic [pwgrle_pkg::LEN_W-1:0] pos_reg, pos_next;
    logic                     first_reg, first_next;
    logic [pwgrle_pkg::RES_PIX-1:0][pwgrle_pkg::PIX_W-1:0] stg_pix_reg, stg_pix_next;
    logic [pwgrle_pkg::PCNT_W-1:0] stg_cnt_reg, stg_cnt_next;
    pwgrle_pkg::result_t      hold_reg, hold_next;
    logic                     hold_done_reg, hold_done_next;
    pwgrle_pkg::result_t      out_reg;
    logic                     out_vld_reg, out_vld_next;

    pwgrle_pkg::result_t          built;
    pwgrle_pkg::result_t          out_data;
    logic                         out_load;
    logic                         out_free;
    logic [pwgrle_pkg::PIX_W-1:0] px;
    logic                         run_end;
    logic                         complete;
    logic                         all_done;

    assign out_free = !out_vld_reg || m_tready;

    always_comb begin
        px = cur_reg.lit ? (pos_reg[0] ? rd1_data : rd0_data) : cur_reg.pixel;
        run_end  = ((pos_reg + pwgrle_pkg::LEN_W'(1)) == cur_reg.len);
        complete = run_end ||
                   ((stg_cnt_reg + pwgrle_pkg::PCNT_W'(1)) ==
                    pwgrle_pkg::PCNT_W'(PIXELS_PER_RESULT));

        built.pix = stg_pix_reg;
        for (int i = 0; i < pwgrle_pkg::RES_PIX; i++) begin
            if (pwgrle_pkg::PCNT_W'(i) == stg_cnt_reg) begin
                built.pix[i] = px;
            end
        end
        built.has_count    = first_reg;
        built.count_byte   = first_reg ? cur_reg.count : '0;
        built.pixel_count  = stg_cnt_reg + pwgrle_pkg::PCNT_W'(1);
        built.last_of_step = run_end && !nxt_vld_reg;
        built.line_done    = run_end && !nxt_vld_reg && eol_reg;
    end

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        nxt_vld_next   = nxt_vld_reg;
        eol_next       = eol_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        stg_pix_next   = stg_pix_reg;
        stg_cnt_next   = stg_cnt_reg;
        hold_next      = hold_reg;
        hold_done_next = hold_done_reg;
        out_load       = 1'b0;
        out_data       = hold_reg;
        all_done       = 1'b0;

        case (state_reg)
            pwgrle_pkg::DR_IDLE: begin
                if (job_start) begin
                    cur_next     = job.first;
                    nxt_next     = job.second;
                    nxt_vld_next = job.second_vld;
                    eol_next     = job.eol;
                    pos_next     = '0;
                    first_next   = 1'b1;
                    stg_pix_next = '0;
                    stg_cnt_next = '0;
                    state_next   = pwgrle_pkg::DR_COLLECT;
                end
            end
            pwgrle_pkg::DR_COLLECT: begin
                pos_next = pos_reg + pwgrle_pkg::LEN_W'(1);
                if (!complete) begin
                    stg_pix_next = built.pix;
                    stg_cnt_next = stg_cnt_reg + pwgrle_pkg::PCNT_W'(1);
                end else begin
                    stg_pix_next = '0;
                    stg_cnt_next = '0;
                    first_next   = 1'b0;
                    if (run_end) begin
                        if (nxt_vld_reg) begin
                            cur_next     = nxt_reg;
                            nxt_vld_next = 1'b0;
                            pos_next     = '0;
                            first_next   = 1'b1;
                        end else begin
                            all_done = 1'b1;
                        end
                    end
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_data   = built;
                        state_next = all_done ? pwgrle_pkg::DR_IDLE : pwgrle_pkg::DR_COLLECT;
                    end else begin
                        hold_next      = built;
                        hold_done_next = all_done;
                        state_next     = pwgrle_pkg::DR_HOLD;
                    end
                end
            end
            pwgrle_pkg::DR_HOLD: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_data   = hold_reg;
                    state_next = hold_done_reg ? pwgrle_pkg::DR_IDLE : pwgrle_pkg::DR_COLLECT;
                end
            end
            default: begin
                state_next = pwgrle_pkg::DR_IDLE;
            end
        endcase

        if (out_load) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end else begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pwgrle_pkg::DR_IDLE;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        nxt_reg       <= nxt_next;
        nxt_vld_reg   <= nxt_vld_next;
        eol_reg       <= eol_next;
        pos_reg       <= pos_next;
        first_reg     <= first_next;
        stg_pix_reg   <= stg_pix_next;
        stg_cnt_reg   <= stg_cnt_next;
        hold_reg      <= hold_next;
        hold_done_reg <= hold_done_next;
        if (out_load) begin
            out_reg <= out_data;
        end
    end

    // the store is read every cycle at the pixel the next cycle works on
    assign rd_index = pos_next;
    assign busy     = (state_reg != pwgrle_pkg::DR_IDLE);

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.has_count;
    assign m_tlast  = out_reg.line_done;
    assign m_tdata  = {{pwgrle_pkg::TD_PAD_W{1'b0}}, out_reg.last_of_step, out_reg.pix,
                       out_reg.pixel_count, out_reg.count_byte};

endmodule

// ===== design/pwg_raster_line_run_encoder.sv =====
// top level of the raster line run encoder
// Takes one pixel a beat and compresses each line into PackBits-style runs: a repeat
// run of 2 to MAX_RUN equal pixels gives count length-1 and the pixel once, a literal
// run of n pixels gives count 257-n (0 for one pixel) and the pixels. Each output beat
// carries an optional count byte and up to PIXELS_PER_RESULT pixels. A beat that
// only extends a run does not hold off the input, and the next one can follow at once. A
// beat that closes runs holds off the input while the pixels of those runs are emitted
// (a repeat run counts as one pixel) and while the output side stalls; the literal
// store delivers one pixel per cycle to the result packer while the output is free.
// Literal pixels live in a two-bank store so that starting a literal can write two
// pixels at once. gray_mode masks incoming pixels to bits 7:0 and may change only
// when idle.
`include "pwg_raster_line_run_encoder_macros.svh"

module pwg_raster_line_run_encoder #(
    parameter int unsigned MAX_RUN           = pwgrle_pkg::MAX_RUN_DEF,
    parameter int unsigned PIXELS_PER_RESULT = pwgrle_pkg::PPR_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input pixels
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pwgrle_pkg::PIX_W-1:0]   s_tdata,   // pixel_value[23:0]
    input  logic                           s_tlast,   // end_of_line
    // encoded results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // count_byte[7:0], pixel_count[10:8], pixel_first[34:11], pixel_second[58:35],
    // pixel_third[82:59], pixel_fourth[106:83], last_of_step[107], zero[111:108]
    output logic [pwgrle_pkg::TDATA_W-1:0] m_tdata,
    output logic                           m_tuser,   // has_count
    output logic                           m_tlast,   // line_done
    // gray_mode register
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data
);

    localparam int unsigned BANK_MIN = (MAX_RUN + 1) / 2;
    localparam int unsigned ADDR_W   = (BANK_MIN > 1) ? $clog2(BANK_MIN) : 1;
    localparam int unsigned LEN_W    = pwgrle_pkg::LEN_W;
    localparam int unsigned PIX_W    = pwgrle_pkg::PIX_W;

    logic                      gray_reg;
    pwgrle_pkg::run_mode_t     mode_reg, mode_next;
    logic [PIX_W-1:0]          rep_pix_reg, rep_pix_next;
    logic [LEN_W-1:0]          rep_len_reg, rep_len_next;
    logic [LEN_W-1:0]          lit_len_reg, lit_len_next;
    logic [PIX_W-1:0]          lit_last_reg, lit_last_next;

    logic                      accept;
    logic [PIX_W-1:0]          px;
    pwgrle_pkg::run_t          run_a;
    pwgrle_pkg::run_t          run_b;
    logic                      run_a_vld;
    pwgrle_pkg::job_t          job;
    logic                      job_start;
    logic                      busy;

    logic                      wr0_en, wr1_en;
    logic [ADDR_W-1:0]         wr0_addr, wr1_addr;
    logic [PIX_W-1:0]          wr0_data, wr1_data;
    logic [LEN_W-1:0]          rd_index;
    logic [PIX_W-1:0]          rd0_data, rd1_data;

    logic                      eol_beat;
    logic                      lit_open;
    logic                      lit_len_ok;
    logic [pwgrle_pkg::PCNT_W-1:0] beat_pcnt;
    logic                      pcnt_ok;
    logic                      done_beat;
    logic                      step_end;

    assign s_tready  = !busy;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        px            = gray_reg ? {{(PIX_W - pwgrle_pkg::GRAY_W){1'b0}},
                                    s_tdata[pwgrle_pkg::GRAY_W-1:0]} : s_tdata;
        mode_next     = mode_reg;
        rep_pix_next  = rep_pix_reg;
        rep_len_next  = rep_len_reg;
        lit_len_next  = lit_len_reg;
        lit_last_next = lit_last_reg;
        run_a         = '0;
        run_b         = '0;
        run_a_vld     = 1'b0;
        wr0_en        = 1'b0;
        wr1_en        = 1'b0;
        wr0_addr      = '0;
        wr1_addr      = '0;
        wr0_data      = px;
        wr1_data      = px;

        if (accept) begin
            case (mode_reg)
                pwgrle_pkg::MODE_REPEAT: begin
                    if ((px == rep_pix_reg) && (rep_len_reg < LEN_W'(MAX_RUN))) begin
                        rep_len_next = rep_len_reg + LEN_W'(1);
                    end else if (rep_len_reg >= LEN_W'(2)) begin
                        run_a_vld    = 1'b1;
                        run_a.lit    = 1'b0;
                        run_a.count  = pwgrle_pkg::CNT_W'(rep_len_reg - LEN_W'(1));
                        run_a.pixel  = rep_pix_reg;
                        run_a.len    = LEN_W'(1);
                        rep_pix_next = px;
                        rep_len_next = LEN_W'(1);
                    end else begin
                        // lone candidate pixel and a different one open a literal
                        wr0_en        = 1'b1;
                        wr0_data      = rep_pix_reg;
                        wr1_en        = 1'b1;
                        wr1_data      = px;
                        lit_len_next  = LEN_W'(2);
                        lit_last_next = px;
                        mode_next     = pwgrle_pkg::MODE_LITERAL;
                    end
                end
                pwgrle_pkg::MODE_LITERAL: begin
                    if ((lit_len_reg < LEN_W'(2)) || (lit_len_reg > LEN_W'(MAX_RUN))) begin
                        mode_next    = pwgrle_pkg::MODE_REPEAT;
                        rep_pix_next = px;
                        rep_len_next = LEN_W'(1);
                    end else if (px == lit_last_reg) begin
                        // tentative last pixel starts a repeat run instead
                        run_a_vld    = 1'b1;
                        run_a.lit    = 1'b1;
                        run_a.count  = pwgrle_pkg::lit_count(lit_len_reg - LEN_W'(1));
                        run_a.len    = lit_len_reg - LEN_W'(1);
                        mode_next    = pwgrle_pkg::MODE_REPEAT;
                        rep_pix_next = px;
                        rep_len_next = LEN_W'(2);
                        lit_len_next = '0;
                    end else if (lit_len_reg >= LEN_W'(MAX_RUN)) begin
                        run_a_vld    = 1'b1;
                        run_a.lit    = 1'b1;
                        run_a.count  = pwgrle_pkg::lit_count(lit_len_reg);
                        run_a.len    = lit_len_reg;
                        lit_len_next = '0;
                        mode_next    = pwgrle_pkg::MODE_REPEAT;
                        rep_pix_next = px;
                        rep_len_next = LEN_W'(1);
                    end else begin
                        if (lit_len_reg[0]) begin
                            wr1_en   = 1'b1;
                            wr1_addr = lit_len_reg[ADDR_W:1];
                        end else begin
                            wr0_en   = 1'b1;
                            wr0_addr = lit_len_reg[ADDR_W:1];
                        end
                        lit_len_next  = lit_len_reg + LEN_W'(1);
                        lit_last_next = px;
                    end
                end
                default: begin
                    mode_next    = pwgrle_pkg::MODE_REPEAT;
                    rep_pix_next = px;
                    rep_len_next = LEN_W'(1);
                end
            endcase

            if (s_tlast) begin
                if (mode_next == pwgrle_pkg::MODE_LITERAL) begin
                    run_b.lit   = 1'b1;
                    run_b.count = pwgrle_pkg::lit_count(lit_len_next);
                    run_b.len   = lit_len_next;
                end else begin
                    run_b.lit   = 1'b0;
                    run_b.count = pwgrle_pkg::CNT_W'(rep_len_next - LEN_W'(1));
                    run_b.pixel = rep_pix_next;
                    run_b.len   = LEN_W'(1);
                end
                mode_next    = pwgrle_pkg::MODE_EMPTY;
                lit_len_next = '0;
                rep_len_next = '0;
            end
        end
    end

    always_comb begin
        job.first      = run_a_vld ? run_a : run_b;
        job.second     = run_b;
        job.second_vld = run_a_vld && s_tlast;
        job.eol        = s_tlast;
        job_start      = accept && (run_a_vld || s_tlast);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gray_reg    <= 1'b0;
            mode_reg    <= pwgrle_pkg::MODE_EMPTY;
            rep_pix_reg <= '0;
            rep_len_reg <= '0;
            lit_len_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                gray_reg <= cfg_data;
            end
            mode_reg    <= mode_next;
            rep_pix_reg <= rep_pix_next;
            rep_len_reg <= rep_len_next;
            lit_len_reg <= lit_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        lit_last_reg <= lit_last_next;
    end

    pwgrle_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk     (aclk),
        .wr0_en   (wr0_en),
        .wr0_addr (wr0_addr),
        .wr0_data (wr0_data),
        .wr1_en   (wr1_en),
        .wr1_addr (wr1_addr),
        .wr1_data (wr1_data),
        .rd_addr  (rd_index[ADDR_W:1]),
        .rd0_data (rd0_data),
        .rd1_data (rd1_data)
    );

    pwgrle_drain #(
        .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
    ) u_drain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_start (job_start),
        .job       (job),
        .busy      (busy),
        .rd_index  (rd_index),
        .rd0_data  (rd0_data),
        .rd1_data  (rd1_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    assign eol_beat   = accept && s_tlast;
    assign lit_open   = (mode_reg == pwgrle_pkg::MODE_LITERAL);
    assign lit_len_ok = (lit_len_reg >= LEN_W'(2)) && (lit_len_reg <= LEN_W'(MAX_RUN));
    assign beat_pcnt  = m_tdata[pwgrle_pkg::TD_PCNT_LSB +: pwgrle_pkg::PCNT_W];
    assign pcnt_ok    = (beat_pcnt != '0) &&
                        (beat_pcnt <= pwgrle_pkg::PCNT_W'(PIXELS_PER_RESULT));
    assign done_beat  = m_tvalid && m_tlast;
    assign step_end   = m_tdata[pwgrle_pkg::TD_LOS_BIT];

    // an end of line always flushes, so the input must be held off next cycle
    `PWGRLE_ASSERT_NXT(a_eol_holds_input, aclk, aresetn, eol_beat, !s_tready, "eol not flushed")

    // an open literal always holds between two and MAX_RUN pixels
    `PWGRLE_ASSERT_IMP(a_literal_length, aclk, aresetn, lit_open, lit_len_ok, "bad literal length")

    `PWGRLE_ASSERT_IMP(a_beat_pixel_count, aclk, aresetn, m_tvalid, pcnt_ok, "bad pixel count")

    // line end only on the closing beat of a pixel's results
    `PWGRLE_ASSERT_IMP(a_line_done_closes, aclk, aresetn, done_beat, step_end, "early line end")

endmodule
